FILE: rtl/core/csp_pkg.sv
// Shared types and codes for the capability slot pool.
`default_nettype none
package csp_pkg;

   localparam int KIND_W = 2;
   localparam int ID_W = 8;
   localparam int TYPE_W = 3;
   localparam int WORD_W = 64;
   localparam int STATUS_W = 2;
   localparam int RID_W = 6;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CHECK = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } csp_state_type;

   // One stored capability entry.
   typedef struct packed {
      logic [TYPE_W-1:0] etype;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
   } csp_entry_type;

   // Update to the in-use bits.
   typedef struct packed {
      logic claim;
      logic release_slot;
   } csp_slot_op_type;

endpackage
`default_nettype wire

FILE: rtl/core/csp_if.sv
// Request and response channel interfaces of the capability slot pool.
`default_nettype none
interface csp_req_if;
   logic valid;
   logic ready;
   logic [csp_pkg::KIND_W-1:0] kind;
   logic [csp_pkg::ID_W-1:0] slot_id;
   logic [csp_pkg::TYPE_W-1:0] entry_type;
   logic [csp_pkg::WORD_W-1:0] payload_a;
   logic [csp_pkg::WORD_W-1:0] payload_b;

   modport source (output valid, kind, slot_id, entry_type, payload_a, payload_b,
                   input ready);
   modport sink (input valid, kind, slot_id, entry_type, payload_a, payload_b,
                 output ready);
endinterface

interface csp_rsp_if;
   logic valid;
   logic ready;
   logic [csp_pkg::STATUS_W-1:0] status;
   logic [csp_pkg::RID_W-1:0] result_id;
   logic [csp_pkg::TYPE_W-1:0] stored_type;
   logic [csp_pkg::WORD_W-1:0] stored_a;
   logic [csp_pkg::WORD_W-1:0] stored_b;

   modport source (output valid, status, result_id, stored_type, stored_a, stored_b,
                   input ready);
   modport sink (input valid, status, result_id, stored_type, stored_a, stored_b,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/csp_slot_mem.sv
// Entry memory holding the type and payload words of every slot.
`default_nettype none
module csp_slot_mem #(
   parameter int POOL_DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire csp_pkg::csp_entry_type wr_data,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output      csp_pkg::csp_entry_type rd_data_ff
);

   csp_pkg::csp_entry_type mem [POOL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/csp_alloc.sv
// In-use bits of the pool with the lowest-free-slot priority encoder.
`default_nettype none
module csp_alloc #(
   parameter int POOL_DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire csp_pkg::csp_slot_op_type op,
   input  wire logic [IDX_W-1:0]        release_idx,
   input  wire logic [IDX_W-1:0]        query_idx,
   output      logic                    query_in_use,
   output      logic                    free_found,
   output      logic [IDX_W-1:0]        free_idx
);

   logic [POOL_DEPTH-1:0] in_use_ff;
   logic [POOL_DEPTH-1:0] in_use_in;

   // Scan from the top so that the lowest free slot wins.
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign query_in_use = in_use_ff[query_idx];

   always_comb begin
      in_use_in = in_use_ff;
      if (op.claim && free_found) begin
         in_use_in[free_idx] = 1'b1;
      end
      if (op.release_slot) begin
         in_use_in[release_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/capability_slot_pool.sv
// Top level of the capability slot pool: request sequencing and response register.
// An accepted item's status, id and entry read are registered; its result then loads into the response register.
// The next item is accepted only once the current item's result has loaded into the response register.
// A result waiting in the response register does not block acceptance of the next item.
// Synchronous reset frees every slot and empties the response register; the entry
// memory is not cleared, as read data is only used for slots in use.
`default_nettype none
module capability_slot_pool #(
   parameter int POOL_DEPTH = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   csp_req_if.sink   req_ch,
   csp_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(POOL_DEPTH);

   csp_pkg::csp_state_type state_ff;
   csp_pkg::csp_state_type state_in;

   logic                          req_accept;
   logic                          out_load;
   logic                          in_range;
   logic                          query_in_use;
   logic                          live;
   logic                          free_found;
   logic [IDX_W-1:0]              free_idx;
   logic [IDX_W-1:0]              req_idx;
   csp_pkg::csp_slot_op_type      slot_op;
   csp_pkg::csp_entry_type        wr_entry;
   csp_pkg::csp_entry_type        rd_entry;
   logic                          is_alloc;

   logic [csp_pkg::KIND_W-1:0]    pend_kind_ff;
   logic [csp_pkg::STATUS_W-1:0]  pend_status_ff;
   logic [csp_pkg::STATUS_W-1:0]  pend_status_in;
   logic [csp_pkg::RID_W-1:0]     pend_id_ff;
   logic [csp_pkg::RID_W-1:0]     pend_id_in;
   logic [csp_pkg::TYPE_W-1:0]    pend_etype_ff;
   logic                          pend_live_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [csp_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [csp_pkg::STATUS_W-1:0]  rsp_status_in;
   logic [csp_pkg::RID_W-1:0]     rsp_id_ff;
   logic [csp_pkg::TYPE_W-1:0]    rsp_type_ff;
   logic [csp_pkg::TYPE_W-1:0]    rsp_type_in;
   logic [csp_pkg::WORD_W-1:0]    rsp_a_ff;
   logic [csp_pkg::WORD_W-1:0]    rsp_a_in;
   logic [csp_pkg::WORD_W-1:0]    rsp_b_ff;
   logic [csp_pkg::WORD_W-1:0]    rsp_b_in;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign is_alloc = (req_ch.kind == csp_pkg::KIND_ALLOC);
   assign req_idx = req_ch.slot_id[IDX_W-1:0];
   assign in_range = ({1'b0, req_ch.slot_id} < 9'(POOL_DEPTH));
   assign live = in_range && query_in_use;

   assign slot_op.claim = req_accept && is_alloc;
   assign slot_op.release_slot = req_accept && live &&
                                 (req_ch.kind == csp_pkg::KIND_DESTROY);

   assign wr_entry.etype = req_ch.entry_type;
   assign wr_entry.word_a = req_ch.payload_a;
   assign wr_entry.word_b = req_ch.payload_b;

   csp_alloc #(
      .POOL_DEPTH(POOL_DEPTH),
      .IDX_W(IDX_W)
   ) u_alloc (
      .clock(clock),
      .reset(reset),
      .op(slot_op),
      .release_idx(req_idx),
      .query_idx(req_idx),
      .query_in_use(query_in_use),
      .free_found(free_found),
      .free_idx(free_idx)
   );

   csp_slot_mem #(
      .POOL_DEPTH(POOL_DEPTH),
      .IDX_W(IDX_W)
   ) u_mem (
      .clock(clock),
      .wr_en(req_accept && is_alloc && free_found),
      .wr_addr(free_idx),
      .wr_data(wr_entry),
      .rd_en(req_accept && !is_alloc),
      .rd_addr(req_idx),
      .rd_data_ff(rd_entry)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csp_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = csp_pkg::ST_EXEC;
            end
         end
         csp_pkg::ST_EXEC: begin
            if (out_load) begin
               state_in = csp_pkg::ST_IDLE;
            end
         end
         default: state_in = csp_pkg::ST_IDLE;
      endcase
   end

   // State outputs: the result register may be loaded once it is empty or being drained.
   always_comb begin
      req_ch.ready = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         csp_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         csp_pkg::ST_EXEC: begin
            out_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Status and id that are settled at acceptance.
   always_comb begin
      if (is_alloc) begin
         pend_status_in = free_found ? csp_pkg::STATUS_OK : csp_pkg::STATUS_EXHAUSTED;
         pend_id_in = free_found ? csp_pkg::RID_W'(8'(free_idx)) : '0;
      end else begin
         pend_status_in = live ? csp_pkg::STATUS_OK : csp_pkg::STATUS_BAD_ID;
         pend_id_in = req_ch.slot_id[csp_pkg::RID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_kind_ff <= req_ch.kind;
         pend_status_ff <= pend_status_in;
         pend_id_ff <= pend_id_in;
         pend_etype_ff <= req_ch.entry_type;
         pend_live_ff <= live;
      end
   end

   // Final result once the entry has been read.
   always_comb begin
      rsp_status_in = pend_status_ff;
      rsp_type_in = '0;
      rsp_a_in = '0;
      rsp_b_in = '0;
      if (pend_live_ff && (pend_kind_ff == csp_pkg::KIND_CHECK) &&
          (rd_entry.etype != pend_etype_ff)) begin
         rsp_status_in = csp_pkg::STATUS_MISMATCH;
      end
      if (pend_live_ff && (pend_kind_ff == csp_pkg::KIND_LOOKUP)) begin
         rsp_type_in = rd_entry.etype;
         rsp_a_in = rd_entry.word_a;
         rsp_b_in = rd_entry.word_b;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff <= pend_id_ff;
         rsp_type_ff <= rsp_type_in;
         rsp_a_ff <= rsp_a_in;
         rsp_b_ff <= rsp_b_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.result_id = rsp_id_ff;
   assign rsp_ch.stored_type = rsp_type_ff;
   assign rsp_ch.stored_a = rsp_a_ff;
   assign rsp_ch.stored_b = rsp_b_ff;

   // A new result only ever comes from the execute step.
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == csp_pkg::ST_EXEC))
      else $error("response raised without an execute step");

   // A granted slot must not be offered again on the next cycle.
   a_grant_taken: assert property (@(posedge clock) disable iff (reset)
      slot_op.claim && free_found |=> !free_found || (free_idx != $past(free_idx)))
      else $error("granted slot still reported free");

   // No item is taken while one is still being executed.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ch.ready)
      else $error("item accepted while another is in flight");

endmodule
`default_nettype wire
